// ----- rtl/rrsg_pkg.sv -----
// Shared widths, register map and constants for the rounded rectangle span generator.
package rrsg_pkg;

  // Default clip ceiling for surface dimensions
  localparam int unsigned MaxSurfaceDimDef = 8192;

  // APB register map: register index is paddr[4:2]
  localparam int unsigned PaddrW = 5;
  localparam logic [2:0] REG_RECT_LEFT      = 3'd0;
  localparam logic [2:0] REG_RECT_TOP       = 3'd1;
  localparam logic [2:0] REG_RECT_WIDTH     = 3'd2;
  localparam logic [2:0] REG_RECT_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_CORNER_RADIUS  = 3'd4;
  localparam logic [2:0] REG_SURFACE_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SURFACE_HEIGHT = 3'd6;
  localparam logic [2:0] REG_FILL_COLOR     = 3'd7;

  // Square root unit sizing: 28-bit radicand, 14-bit root, one root bit per step
  localparam int unsigned RadW      = 28;
  localparam int unsigned RootW     = 14;
  localparam int unsigned SqrtSteps = 14;
  localparam int unsigned SqrtCntW  = 4;

endpackage

// ----- rtl/rrsg_isqrt.sv -----
// Iterative digit-by-digit integer square root, one root bit per cycle.
module rrsg_isqrt import rrsg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0]     rad_q, rad_d;
  logic [14:0]         rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  logic [SqrtCntW-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [16:0] rem_sh;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        take;

  // One restoring step: bring down two radicand bits, try (root<<2)|1
  always_comb begin
    rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
  end

  // Sequencing of the shared step
  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[RadW-3:0], 2'b00};
      rem_d  = take ? diff[14:0] : rem_sh[14:0];
      root_d = {root_q[RootW-2:0], take};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == SqrtCntW'(SqrtSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/rounded_rect_span_generator_unit.sv -----
// Top level: APB register file, span sequencer with a shared multiplier, output register.
//
// Usage: program the rectangle, radius, surface size and colour over the APB port
// (register i at byte address 4*i, pready always high, writes only while idle).
// Each row index is a transfer on in_valid_i/in_ready_o; each result is a transfer
// on out_valid_o/out_ready_i carrying the clipped span, the surface row, an empty
// flag and the fill colour. Exactly one result per row.
// Path from input transfer to out_valid_o: two passes through the shared 14x14
// multiplier (r*r, dy*dy), 14 iterations of the bit-serial square root unit, a
// step that collects the root and a clip step.
// The sequencer takes no new row until the current one has left the clip step;
// in_ready_o is high only while the sequencer is idle.
// A finished result waits in the output register; the sequencer accepts the next
// row meanwhile and, if the result is still untaken when the next clip is due,
// holds in the clip step until the output register frees.
// Reset: all registers read zero, nothing in flight, out_valid_o low.
module rounded_rect_span_generator_unit import rrsg_pkg::*; #(
  parameter int unsigned MAX_SURFACE_DIM = MaxSurfaceDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Row input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [14:0]       row_index_i,
  // Span output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [13:0]       span_start_o,
  output logic [13:0]       span_end_o,
  output logic [12:0]       span_row_o,
  output logic              span_empty_o,
  output logic [31:0]       span_color_o
);

  localparam logic [16:0] MaxDim = 17'(MAX_SURFACE_DIM);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DY   = 3'd1;
  localparam logic [2:0] ST_SUB  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_CLIP = 3'd4;

  // Configuration registers
  logic [15:0] rect_left_q, rect_top_q;
  logic [14:0] rect_width_q, rect_height_q, corner_radius_q;
  logic [13:0] surface_width_q, surface_height_q;
  logic [31:0] fill_color_q;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q      <= '0;
      rect_top_q       <= '0;
      rect_width_q     <= '0;
      rect_height_q    <= '0;
      corner_radius_q  <= '0;
      surface_width_q  <= '0;
      surface_height_q <= '0;
      fill_color_q     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RECT_LEFT:      rect_left_q      <= pwdata[15:0];
        REG_RECT_TOP:       rect_top_q       <= pwdata[15:0];
        REG_RECT_WIDTH:     rect_width_q     <= pwdata[14:0];
        REG_RECT_HEIGHT:    rect_height_q    <= pwdata[14:0];
        REG_CORNER_RADIUS:  corner_radius_q  <= pwdata[14:0];
        REG_SURFACE_WIDTH:  surface_width_q  <= pwdata[13:0];
        REG_SURFACE_HEIGHT: surface_height_q <= pwdata[13:0];
        REG_FILL_COLOR:     fill_color_q     <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_idx)
      REG_RECT_LEFT:      prdata = {16'd0, rect_left_q};
      REG_RECT_TOP:       prdata = {16'd0, rect_top_q};
      REG_RECT_WIDTH:     prdata = {17'd0, rect_width_q};
      REG_RECT_HEIGHT:    prdata = {17'd0, rect_height_q};
      REG_CORNER_RADIUS:  prdata = {17'd0, corner_radius_q};
      REG_SURFACE_WIDTH:  prdata = {18'd0, surface_width_q};
      REG_SURFACE_HEIGHT: prdata = {18'd0, surface_height_q};
      REG_FILL_COLOR:     prdata = fill_color_q;
      default:            prdata = '0;
    endcase
  end

  // Sequencer and working registers
  logic [2:0]        state_q, state_d;
  logic [14:0]       row_q;
  logic [13:0]       r_q;
  logic [13:0]       dy_q;
  logic [RadW-1:0]   rr_q;
  logic [13:0]       dx_q;
  logic [17:0]       sy_q;
  logic              off_q;

  logic              in_xfer, out_xfer;
  logic              clip_go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign out_xfer   = out_valid_o & out_ready_i;
  assign clip_go    = (state_q == ST_CLIP) && (!out_valid_o || out_ready_i);

  // Radius clamp to half width then half height; surface row and row checks
  logic [14:0] rc1, rc2;
  logic [17:0] sy_d;
  logic [16:0] sh_c, sw_c;
  logic        off_d;

  always_comb begin
    rc1  = ({1'b0, corner_radius_q} << 1) > {1'b0, rect_width_q}
           ? (rect_width_q >> 1) : corner_radius_q;
    rc2  = ({1'b0, rc1} << 1) > {1'b0, rect_height_q}
           ? (rect_height_q >> 1) : rc1;
    sh_c = ({3'd0, surface_height_q} > MaxDim) ? MaxDim : {3'd0, surface_height_q};
    sw_c = ({3'd0, surface_width_q} > MaxDim) ? MaxDim : {3'd0, surface_width_q};
    sy_d = {{2{rect_top_q[15]}}, rect_top_q} + {3'd0, row_index_i};
    off_d = (row_index_i >= rect_height_q) || sy_d[17] || (sy_d >= {1'b0, sh_c});
  end

  // Distance from the corner-circle centre row
  logic [14:0] h_minus_r;
  logic [14:0] dy_full;

  always_comb begin
    h_minus_r = rect_height_q - {1'b0, r_q};
    if (row_q < {1'b0, r_q})
      dy_full = {1'b0, r_q} - row_q;
    else if (row_q >= h_minus_r)
      dy_full = row_q - h_minus_r + 15'd1;
    else
      dy_full = '0;
  end

  // Shared multiplier: r*r first, then dy*dy
  logic [13:0]     mul_a;
  logic [RadW-1:0] mul_p;
  logic [RadW-1:0] lim;

  assign mul_a = (state_q == ST_DY) ? r_q : dy_q;
  assign mul_p = mul_a * mul_a;
  assign lim   = rr_q - mul_p;

  // Square root unit
  logic             sq_start, sq_done;
  logic [RootW-1:0] sq_root;

  assign sq_start = (state_q == ST_SUB);

  rrsg_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (lim),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_DY;
      ST_DY:   state_d = ST_SUB;
      ST_SUB:  state_d = ST_SQRT;
      ST_SQRT: if (sq_done) state_d = ST_CLIP;
      ST_CLIP: if (clip_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      row_q <= row_index_i;
      r_q   <= rc2[13:0];
      sy_q  <= sy_d;
      off_q <= off_d;
    end
    if (state_q == ST_DY) begin
      dy_q <= dy_full[13:0];
      rr_q <= mul_p;
    end
    if ((state_q == ST_SQRT) && sq_done) begin
      dx_q <= (dy_q != '0) ? (r_q - sq_root) : '0;
    end
  end

  // Span ends and clipping
  logic [18:0] x0, x1, x0c, x1c;
  logic        span_empty_d;

  always_comb begin
    x0  = {{3{rect_left_q[15]}}, rect_left_q} + {5'd0, dx_q};
    x1  = x0 + {4'd0, rect_width_q} - {4'd0, dx_q, 1'b0};
    x0c = x0[18] ? '0 : x0;
    x1c = ($signed(x1) > $signed({2'b00, sw_c})) ? {2'b00, sw_c} : x1;
    span_empty_d = off_q || ($signed(x0c) >= $signed(x1c));
  end

  // Output register
  logic        out_valid_q;
  logic [13:0] span_start_q, span_end_q;
  logic [12:0] span_row_q;
  logic        span_empty_q;
  logic [31:0] span_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clip_go) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clip_go) begin
      span_empty_q <= span_empty_d;
      span_color_q <= fill_color_q;
      if (span_empty_d) begin
        span_start_q <= '0;
        span_end_q   <= '0;
        span_row_q   <= '0;
      end else begin
        span_start_q <= x0c[13:0];
        span_end_q   <= x1c[13:0];
        span_row_q   <= sy_q[12:0];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign span_start_o = span_start_q;
  assign span_end_o   = span_end_q;
  assign span_row_o   = span_row_q;
  assign span_empty_o = span_empty_q;
  assign span_color_o = span_color_q;

endmodule
